// File: rtl/ilir_pkg.sv
// Package for the indexed list: field widths, command and status codes,
// controller state type and the controller-to-datapath command struct.
// No dependencies.
package ilir_pkg;

  localparam int ILIR_DEPTH = 16;
  localparam int ILIR_WIDTH = 32;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 4;
  localparam int VALUE_W = 32;
  localparam int STS_W   = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND   = 3'd0,
    CMD_INSERT   = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_POP      = 3'd3,
    CMD_READ     = 3'd4,
    CMD_WRITE    = 3'd5
  } ilir_op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_RANGE = 2'd2,
    STS_EMPTY = 2'd3
  } ilir_status_t;

  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_EXEC = 1'b1
  } ilir_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ilir_cmd_t;

endpackage

// File: rtl/ilir_if.sv
// Valid/ready channel interfaces for the indexed list: command and result.
// Depends on ilir_pkg for the field widths.
interface ilir_req_if import ilir_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

interface ilir_rsp_if import ilir_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] read_value;
  logic [STS_W-1:0]   status;
  logic [COUNT_W-1:0] count;

  modport source (output valid, read_value, status, count, input ready);
  modport sink   (input valid, read_value, status, count, output ready);
endinterface

// File: rtl/ilir_ctrl.sv
// Controller for the indexed list: takes a command, schedules its commit
// and owns the result valid flag. Depends on ilir_pkg.
module ilir_ctrl import ilir_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output ilir_cmd_t cmd
);

  ilir_state_t state, state_next;
  logic        out_valid, out_valid_next;
  logic        out_free;

  assign out_free = !out_valid || rsp_ready;

  always_comb begin
    state_next = state;
    case (state)
      CTL_IDLE: begin
        if (req_valid) state_next = CTL_EXEC;
      end
      CTL_EXEC: begin
        if (out_free) state_next = CTL_IDLE;
      end
      default: state_next = CTL_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      CTL_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      CTL_EXEC: begin
        cmd.commit = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) out_valid_next = 1'b1;
    else if (rsp_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CTL_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign rsp_valid = out_valid;

  a_commit_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == CTL_EXEC))
    else $error("command not followed by execute");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !cmd.commit)
    else $error("commit over a pending result");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid)
    else $error("result valid missing after commit");

endmodule

// File: rtl/ilir_dp.sv
// Datapath for the indexed list: entry registers with parallel shift, fill
// count, command decode and the result register. Depends on ilir_pkg.
module ilir_dp import ilir_pkg::*; #(
  parameter int DEPTH = ILIR_DEPTH,
  parameter int WIDTH = ILIR_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  ilir_cmd_t          cmd,
  input  logic [CMD_W-1:0]   command,
  input  logic [POS_W-1:0]   position,
  input  logic [VALUE_W-1:0] value,
  output logic [VALUE_W-1:0] read_value,
  output logic [STS_W-1:0]   status,
  output logic [COUNT_W-1:0] count
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int RD_N = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

  logic [CMD_W-1:0]   cmd_q;
  logic [POS_W-1:0]   pos_q;
  logic [WIDTH-1:0]   val_q;
  logic [WIDTH-1:0]   entries [DEPTH];
  logic [WIDTH-1:0]   entries_next [DEPTH];
  logic [WIDTH-1:0]   prev_e [DEPTH];
  logic [WIDTH-1:0]   nxt_e [DEPTH];
  logic [CW-1:0]      fill_count, fill_count_next;
  logic [VALUE_W-1:0] rd_q;
  ilir_status_t       sts_q;
  logic [COUNT_W-1:0] count_q;

  logic               is_empty, is_full, out_range;
  logic [CMPW-1:0]    pos_ext, cnt_ext;
  logic               do_app, do_ins, do_rem, do_pop, do_rd, do_wr;
  ilir_status_t       sts;
  logic [WIDTH-1:0]   rd_entry;
  logic [63:0]        rd_wide;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q <= command;
      pos_q <= position;
      val_q <= WIDTH'(64'(value));
    end
  end

  assign pos_ext   = CMPW'(pos_q);
  assign cnt_ext   = CMPW'(fill_count);
  assign is_empty  = (fill_count == '0);
  assign is_full   = (fill_count == CW'(DEPTH));
  assign out_range = (pos_ext >= cnt_ext);

  always_comb begin
    sts    = STS_OK;
    do_app = 1'b0;
    do_ins = 1'b0;
    do_rem = 1'b0;
    do_pop = 1'b0;
    do_rd  = 1'b0;
    do_wr  = 1'b0;
    case (cmd_q)
      CMD_APPEND: begin
        if (is_full) sts = STS_FULL;
        else do_app = 1'b1;
      end
      CMD_INSERT: begin
        if (is_full) sts = STS_FULL;
        else if (out_range) sts = STS_RANGE;
        else do_ins = 1'b1;
      end
      CMD_REMOVE: begin
        if (is_empty) sts = STS_EMPTY;
        else if (out_range) sts = STS_RANGE;
        else do_rem = 1'b1;
      end
      CMD_POP: begin
        if (is_empty) sts = STS_EMPTY;
        else do_pop = 1'b1;
      end
      CMD_READ: begin
        if (is_empty) sts = STS_EMPTY;
        else if (out_range) sts = STS_RANGE;
        else do_rd = 1'b1;
      end
      CMD_WRITE: begin
        if (is_empty) sts = STS_EMPTY;
        else if (out_range) sts = STS_RANGE;
        else do_wr = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    fill_count_next = fill_count;
    if (do_app || do_ins) fill_count_next = fill_count + CW'(1);
    else if (do_rem || do_pop) fill_count_next = fill_count - CW'(1);
  end

  always_comb begin
    prev_e[0]       = entries[0];
    nxt_e[DEPTH-1]  = entries[DEPTH-1];
    for (int i = 1; i < DEPTH; i++) prev_e[i] = entries[i-1];
    for (int i = 0; i < DEPTH - 1; i++) nxt_e[i] = entries[i+1];
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_next[i] = entries[i];
      if (do_app && (cnt_ext == CMPW'(i))) entries_next[i] = val_q;
      if (do_ins) begin
        if (pos_ext == CMPW'(i)) entries_next[i] = val_q;
        else if ((CMPW'(i) > pos_ext) && (CMPW'(i) <= cnt_ext)) entries_next[i] = prev_e[i];
      end
      if (do_rem && (CMPW'(i) >= pos_ext) && (CMPW'(i) + CMPW'(1) < cnt_ext))
        entries_next[i] = nxt_e[i];
      if (do_wr && (pos_ext == CMPW'(i))) entries_next[i] = val_q;
    end
  end

  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (pos_q == POS_W'(i)) rd_entry = entries[i];
    end
  end

  assign rd_wide = 64'(rd_entry);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < DEPTH; i++) entries[i] <= entries_next[i];
      rd_q    <= do_rd ? rd_wide[VALUE_W-1:0] : '0;
      sts_q   <= sts;
      count_q <= COUNT_W'(fill_count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.commit) begin
      fill_count <= fill_count_next;
    end
  end

  assign read_value = rd_q;
  assign status     = sts_q;
  assign count      = count_q;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(fill_count))
    else $error("fill count moved without commit");

  a_fail_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (sts != STS_OK)) |=> (fill_count == $past(fill_count)))
    else $error("failed command changed fill count");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (count == COUNT_W'(fill_count)))
    else $error("result count differs from fill count");

endmodule

// File: rtl/indexed_list_insert_remove.sv
// Top level of the indexed list: command channel in, result channel out.
// Depends on ilir_pkg, ilir_if, ilir_ctrl and ilir_dp.
//
//   channel  dir  payload                      transfer
//   req      in   command, position, value     req.valid && req.ready
//   rsp      out  read_value, status, count    rsp.valid && rsp.ready
//
// Each command is first registered, then decoded; the entries are shifted
// or written in parallel and the result register is loaded.
// The next command is taken while a result waits; its commit waits for
// the result register to free up. Reset empties the list.
module indexed_list_insert_remove import ilir_pkg::*; #(
  parameter int DEPTH = ILIR_DEPTH,
  parameter int WIDTH = ILIR_WIDTH
) (
  input logic       clk,
  input logic       rst,
  ilir_req_if.sink  req,
  ilir_rsp_if.source rsp
);

  ilir_cmd_t cmd;

  ilir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  ilir_dp #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .command    (req.command),
    .position   (req.position),
    .value      (req.value),
    .read_value (rsp.read_value),
    .status     (rsp.status),
    .count      (rsp.count)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Testbench for indexed_list_insert_remove: sends list commands over the req
// channel, predicts each result from a shadow copy of the list, checks rsp.
// Depends on ilir_pkg, ilir_if and the RTL of the block.
module testbench;
  import ilir_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int IDLE_PCT = 37;
  localparam int DRAIN_CYCLES = 10;
  localparam int BIAS_GROW = 0;
  localparam int BIAS_SHRINK = 1;
  localparam int BIAS_EVEN = 2;

  typedef struct {
    logic [VALUE_W-1:0] read_value;
    ilir_status_t       status;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ilir_req_if req ();
  ilir_rsp_if rsp ();

  indexed_list_insert_remove dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  logic [VALUE_W-1:0] shadow_entries [ILIR_DEPTH];
  int                 shadow_len = 0;
  list_result_t       pending_results [$];
  list_result_t       oldest;
  bit                 back_to_back = 1'b0;
  int                 mismatches = 0;
  int                 commands_sent = 0;
  int                 results_seen = 0;
  int                 status_hits [4] = '{0, 0, 0, 0};
  int                 full_list_hits = 0;

  function automatic list_result_t apply_list_command(logic [CMD_W-1:0] cmd,
      logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
    list_result_t r;
    r.read_value = '0;
    r.status = STS_OK;
    case (cmd)
      CMD_APPEND: begin
        if (shadow_len >= ILIR_DEPTH) begin
          r.status = STS_FULL;
        end else begin
          shadow_entries[shadow_len] = val;
          shadow_len++;
        end
      end
      CMD_INSERT: begin
        if (shadow_len >= ILIR_DEPTH) begin
          r.status = STS_FULL;
        end else if (int'(pos) >= shadow_len) begin
          r.status = STS_RANGE;
        end else begin
          for (int i = shadow_len; i > int'(pos); i--)
            shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[pos] = val;
          shadow_len++;
        end
      end
      CMD_REMOVE: begin
        if (shadow_len == 0) begin
          r.status = STS_EMPTY;
        end else if (int'(pos) >= shadow_len) begin
          r.status = STS_RANGE;
        end else begin
          for (int i = int'(pos); i + 1 < shadow_len; i++)
            shadow_entries[i] = shadow_entries[i+1];
          shadow_len--;
        end
      end
      CMD_POP: begin
        if (shadow_len == 0) r.status = STS_EMPTY;
        else shadow_len--;
      end
      CMD_READ: begin
        if (shadow_len == 0) r.status = STS_EMPTY;
        else if (int'(pos) >= shadow_len) r.status = STS_RANGE;
        else r.read_value = shadow_entries[pos];
      end
      CMD_WRITE: begin
        if (shadow_len == 0) r.status = STS_EMPTY;
        else if (int'(pos) >= shadow_len) r.status = STS_RANGE;
        else shadow_entries[pos] = val;
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(shadow_len);
    return r;
  endfunction

  task automatic send_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
      logic [VALUE_W-1:0] val);
    @(negedge clk);
    while (!back_to_back && $urandom_range(99) < IDLE_PCT) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.command = cmd;
    req.position = pos;
    req.value = val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_results.push_back(apply_list_command(cmd, pos, val));
    if (shadow_len == ILIR_DEPTH) full_list_hits++;
    commands_sent++;
  endtask

  // Mostly well-formed commands aimed at live slots; some noise on top.
  task automatic send_shaped(int bias);
    logic [CMD_W-1:0]   cmd;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    int                 roll;
    val = $urandom();
    if ($urandom_range(9) == 0) val = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(99) < 10) begin
      cmd = CMD_W'($urandom_range(7));
      pos = POS_W'($urandom_range(15));
    end else begin
      roll = $urandom_range(99);
      case (bias)
        BIAS_GROW: begin
          if (roll < 35) cmd = CMD_APPEND;
          else if (roll < 65) cmd = CMD_INSERT;
          else if (roll < 75) cmd = CMD_REMOVE;
          else if (roll < 80) cmd = CMD_POP;
          else if (roll < 90) cmd = CMD_READ;
          else cmd = CMD_WRITE;
        end
        BIAS_SHRINK: begin
          if (roll < 10) cmd = CMD_APPEND;
          else if (roll < 20) cmd = CMD_INSERT;
          else if (roll < 50) cmd = CMD_REMOVE;
          else if (roll < 70) cmd = CMD_POP;
          else if (roll < 85) cmd = CMD_READ;
          else cmd = CMD_WRITE;
        end
        default: begin
          if (roll < 20) cmd = CMD_APPEND;
          else if (roll < 40) cmd = CMD_INSERT;
          else if (roll < 60) cmd = CMD_REMOVE;
          else if (roll < 70) cmd = CMD_POP;
          else if (roll < 85) cmd = CMD_READ;
          else cmd = CMD_WRITE;
        end
      endcase
      if (shadow_len > 0 && $urandom_range(9) != 0)
        pos = POS_W'($urandom_range(shadow_len - 1));
      else pos = POS_W'($urandom_range(15));
    end
    send_command(cmd, pos, val);
  endtask

  task automatic test_empty_list();
    send_command(CMD_POP, 4'd0, '0);
    send_command(CMD_REMOVE, 4'd0, '0);
    send_command(CMD_READ, 4'd0, '0);
    send_command(CMD_WRITE, 4'd15, '1);
    send_command(CMD_INSERT, 4'd0, 32'h1234_5678);
    send_command(CMD_SPARE_LO, 4'd15, '1);
    send_command(CMD_SPARE_HI, 4'd0, '0);
  endtask

  task automatic test_fill_to_capacity();
    send_command(CMD_APPEND, 4'd0, '0);
    send_command(CMD_APPEND, 4'd15, '1);
    send_command(CMD_APPEND, 4'd5, 32'h5555_5555);
    send_command(CMD_APPEND, 4'd10, 32'hAAAA_AAAA);
    for (int k = 4; k < ILIR_DEPTH; k++)
      send_command(CMD_APPEND, 4'($urandom_range(15)), $urandom());
    send_command(CMD_APPEND, 4'd0, '1);
    send_command(CMD_INSERT, 4'd0, '1);
    send_command(CMD_READ, 4'd15, '0);
    send_command(CMD_WRITE, 4'd15, '0);
  endtask

  task automatic test_random_mix(int n_items);
    int bias;
    bias = BIAS_EVEN;
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) bias = $urandom_range(2);
      send_shaped(bias);
    end
  endtask

  task automatic test_back_to_back(int n_items);
    back_to_back = 1'b1;
    for (int k = 0; k < n_items; k++)
      send_shaped(k < n_items / 3 ? BIAS_GROW : (k < 2 * n_items / 3 ? BIAS_SHRINK : BIAS_EVEN));
    back_to_back = 1'b0;
  endtask

  always @(negedge clk) begin
    rsp.ready = back_to_back || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected transfer: read_value %h status %0d count %0d",
               rsp.read_value, rsp.status, rsp.count);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        status_hits[oldest.status]++;
        if (rsp.read_value !== oldest.read_value) begin
          $error("read_value: expected %h, actual %h", oldest.read_value, rsp.read_value);
          mismatches++;
        end
        if (rsp.status !== oldest.status) begin
          $error("status: expected %0d, actual %0d", oldest.status, rsp.status);
          mismatches++;
        end
        if (rsp.count !== oldest.count) begin
          $error("count: expected %0d, actual %0d", oldest.count, rsp.count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    req.valid = 1'b0;
    req.command = '0;
    req.position = '0;
    req.value = '0;
    for (int i = 0; i < ILIR_DEPTH; i++) shadow_entries[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_list();
    test_fill_to_capacity();
    test_random_mix(700);
    test_back_to_back(250);

    @(negedge clk);
    req.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands, %0d results, list full after %0d of them",
             commands_sent, results_seen, full_list_hits);
    $display("status mix: ok %0d, full %0d, out of range %0d, empty %0d",
             status_hits[STS_OK], status_hits[STS_FULL], status_hits[STS_RANGE],
             status_hits[STS_EMPTY]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ilir_pkg.sv
rtl/ilir_if.sv
rtl/ilir_ctrl.sv
rtl/ilir_dp.sv
rtl/indexed_list_insert_remove.sv
bench/testbench.sv
